@@ rtl/nixie_pkg.sv @@
`default_nettype none
package nixie_pkg;

  // longest fixed animation in seconds, ten ticks each
  localparam int MAX_ANIM_SECONDS = 255;
  localparam int SEC_W            = $clog2(MAX_ANIM_SECONDS + 1);
  localparam int SEC_CMP_W        = (SEC_W > 8) ? SEC_W : 8;
  localparam int PROD_W           = SEC_CMP_W + 4;
  localparam int TICK_W           = 12;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // event codes
  localparam logic [1:0] CMD_MINUTE    = 2'd0;
  localparam logic [1:0] CMD_HALF_SEC  = 2'd1;
  localparam logic [1:0] CMD_ANIM_TICK = 2'd2;
  localparam logic [1:0] CMD_REFRESH   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_MANUAL      = 3'd1;
  localparam logic [2:0] REG_SLEEP_START = 3'd2;
  localparam logic [2:0] REG_SLEEP_END   = 3'd3;
  localparam logic [2:0] REG_ANIM_HOUR   = 3'd4;
  localparam logic [2:0] REG_ANIM_SECS   = 3'd5;

  localparam logic [6:0] MODE_RESET = 7'd25;

  // mode flag bit positions
  localparam int MODE_TUBES  = 0;
  localparam int MODE_MANUAL = 1;
  localparam int MODE_SLEEP  = 2;
  localparam int MODE_LAMP   = 3;
  localparam int MODE_BLINK  = 4;
  localparam int MODE_FIXED  = 5;
  localparam int MODE_HOURLY = 6;

  typedef struct packed {
    logic [6:0]  mode_flags;
    logic [15:0] manual_digits;
    logic [10:0] sleep_start_minute;
    logic [10:0] sleep_end_minute;
    logic [4:0]  fixed_anim_hour;
    logic [7:0]  fixed_anim_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       first_half;
  } item_t;

  typedef struct packed {
    logic [3:0] digit_one;
    logic [3:0] digit_two;
    logic [3:0] digit_three;
    logic [3:0] digit_four;
    logic       tubes_blank;
    logic       neon_lit;
    logic       animating;
  } result_t;

  // quotient by ten through reciprocal, exact for six-bit values
  function automatic logic [3:0] div10(input logic [5:0] v);
    logic [14:0] p;
    p = {9'd0, v} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [3:0] q;
    logic [6:0] t;
    logic [6:0] r;
    q = div10(v);
    t = {q, 3'b000} + {2'b00, q, 1'b0};
    r = {1'b0, v} - t;
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/nixie_clock_display_controller_core.sv @@
`default_nettype none
// channel  direction  handshake                 payload
// in_      slave      in_tvalid / in_tready      one event item (tuser command, tdata time)
// out_     master     out_tvalid / out_tready    one display item per event
// cfg_     apb slave  psel, penable, pready      six control registers at 4*index
//
// every item passes from acceptance to result through the input register, then
// through the display logic into the result register
// a new item is accepted every cycle while results are being taken
// stalls: the input register holds while the result register is full and
// unread; in_tready falls only when both stages hold an item
// reset (rst_n low, synchronous) clears the tube state and the valid flags,
// registers return to their reset values
module nixie_clock_display_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // hour[4:0], minute[10:5], first_half[11], zero
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // digit_one, digit_two, digit_three, digit_four,
                                       // tubes_blank[16], neon_lit[17], animating[18], zero
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  nixie_pkg::cfg_t    cfg;
  nixie_pkg::item_t   item_r;
  nixie_pkg::result_t res;
  nixie_pkg::result_t res_r;
  logic               in_valid_r;
  logic               out_valid_r;
  logic               advance;

  assign cfg_pready = 1'b1;

  nixie_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // item moves from the input register into the result register
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.command    <= in_tuser;
      item_r.hour       <= in_tdata[4:0];
      item_r.minute     <= in_tdata[10:5];
      item_r.first_half <= in_tdata[11];
    end
  end

  nixie_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.animating, res_r.neon_lit, res_r.tubes_blank,
                       res_r.digit_four, res_r.digit_three, res_r.digit_two,
                       res_r.digit_one};

  // blank tubes carry zero digits
  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.tubes_blank |-> out_tdata[15:0] == 16'd0)
    else $error("blank result with non-zero digits");

  // animation shows one digit on every tube and never blanks
  a_anim_uniform: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.animating |->
      !res_r.tubes_blank && res_r.digit_one == res_r.digit_two &&
      res_r.digit_two == res_r.digit_three && res_r.digit_three == res_r.digit_four)
    else $error("animation result not uniform");

  // back pressure only when both stages are occupied and the output stalls
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

  // lamp switched off means no colon drive
  a_lamp_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !cfg.mode_flags[nixie_pkg::MODE_LAMP] |-> !res_r.neon_lit)
    else $error("colon lit with lamp disabled");

endmodule
`default_nettype wire

@@ rtl/nixie_cfg_regs.sv @@
`default_nettype none
module nixie_cfg_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [4:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output nixie_pkg::cfg_t      cfg
);

  nixie_pkg::cfg_t cfg_r;
  logic [2:0]      idx;
  logic            wr;

  assign idx = paddr[4:2];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_flags         <= nixie_pkg::MODE_RESET;
      cfg_r.manual_digits      <= '0;
      cfg_r.sleep_start_minute <= '0;
      cfg_r.sleep_end_minute   <= '0;
      cfg_r.fixed_anim_hour    <= '0;
      cfg_r.fixed_anim_seconds <= '0;
    end else if (wr) begin
      case (idx)
        nixie_pkg::REG_MODE:        cfg_r.mode_flags         <= pwdata[6:0];
        nixie_pkg::REG_MANUAL:      cfg_r.manual_digits      <= pwdata[15:0];
        nixie_pkg::REG_SLEEP_START: cfg_r.sleep_start_minute <= pwdata[10:0];
        nixie_pkg::REG_SLEEP_END:   cfg_r.sleep_end_minute   <= pwdata[10:0];
        nixie_pkg::REG_ANIM_HOUR:   cfg_r.fixed_anim_hour    <= pwdata[4:0];
        nixie_pkg::REG_ANIM_SECS:   cfg_r.fixed_anim_seconds <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      nixie_pkg::REG_MODE:        prdata = {25'd0, cfg_r.mode_flags};
      nixie_pkg::REG_MANUAL:      prdata = {16'd0, cfg_r.manual_digits};
      nixie_pkg::REG_SLEEP_START: prdata = {21'd0, cfg_r.sleep_start_minute};
      nixie_pkg::REG_SLEEP_END:   prdata = {21'd0, cfg_r.sleep_end_minute};
      nixie_pkg::REG_ANIM_HOUR:   prdata = {27'd0, cfg_r.fixed_anim_hour};
      nixie_pkg::REG_ANIM_SECS:   prdata = {24'd0, cfg_r.fixed_anim_seconds};
      default:                    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/nixie_engine.sv @@
`default_nettype none
module nixie_engine (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire nixie_pkg::item_t item,
  input  wire nixie_pkg::cfg_t  cfg,
  output nixie_pkg::result_t    res
);

  logic [4:0]                     clock_hour_r, clock_hour_nxt;
  logic [5:0]                     clock_minute_r, clock_minute_nxt;
  logic                           blink_phase_r, blink_phase_nxt;
  logic                           anim_running_r, anim_running_nxt;
  logic [nixie_pkg::TICK_W-1:0]   anim_ticks_r, anim_ticks_nxt;
  logic [nixie_pkg::TICK_W-1:0]   anim_limit_r, anim_limit_nxt;
  logic [3:0]                     anim_digit_r, anim_digit_nxt;

  logic [nixie_pkg::SEC_CMP_W-1:0] sec;
  logic [nixie_pkg::PROD_W-1:0]    prod;
  logic [nixie_pkg::TICK_W-1:0]    long_limit;
  logic [nixie_pkg::TICK_W-1:0]    ticks_inc;
  logic [10:0]                     now;
  logic                            in_sleep;
  logic [6:0]                      mf;

  assign mf = cfg.mode_flags;

  // long animation limit: clamp seconds, times ten, saturate
  always_comb begin
    sec = nixie_pkg::SEC_CMP_W'(cfg.fixed_anim_seconds);
    if (sec > nixie_pkg::SEC_CMP_W'(nixie_pkg::MAX_ANIM_SECONDS))
      sec = nixie_pkg::SEC_CMP_W'(nixie_pkg::MAX_ANIM_SECONDS);
    prod = {1'b0, sec, 3'b000} + {3'b000, sec, 1'b0};
    if (prod > nixie_pkg::PROD_W'(nixie_pkg::TICK_MAX))
      long_limit = nixie_pkg::TICK_MAX;
    else
      long_limit = prod[nixie_pkg::TICK_W-1:0];
  end

  assign ticks_inc = anim_ticks_r + 1'b1;

  always_comb begin
    clock_hour_nxt   = clock_hour_r;
    clock_minute_nxt = clock_minute_r;
    blink_phase_nxt  = blink_phase_r;
    anim_running_nxt = anim_running_r;
    anim_ticks_nxt   = anim_ticks_r;
    anim_limit_nxt   = anim_limit_r;
    anim_digit_nxt   = anim_digit_r;
    if (en) begin
      case (item.command)
        nixie_pkg::CMD_MINUTE: begin
          clock_hour_nxt   = item.hour;
          clock_minute_nxt = item.minute;
          if (!anim_running_r && item.minute == 6'd0) begin
            if (mf[nixie_pkg::MODE_FIXED] && item.hour == cfg.fixed_anim_hour) begin
              anim_running_nxt = 1'b1;
              anim_ticks_nxt   = '0;
              anim_digit_nxt   = 4'd0;
              anim_limit_nxt   = long_limit;
            end else if (mf[nixie_pkg::MODE_HOURLY]) begin
              anim_running_nxt = 1'b1;
              anim_ticks_nxt   = '0;
              anim_digit_nxt   = 4'd0;
              anim_limit_nxt   = nixie_pkg::TICK_W'(10);
            end
          end
        end
        nixie_pkg::CMD_HALF_SEC: blink_phase_nxt = item.first_half;
        nixie_pkg::CMD_ANIM_TICK: begin
          if (anim_running_r) begin
            anim_ticks_nxt = ticks_inc;
            // digit tracks ticks mod ten; a wrap of the count restarts it
            if (ticks_inc == '0 || anim_digit_r == 4'd9)
              anim_digit_nxt = 4'd0;
            else
              anim_digit_nxt = anim_digit_r + 4'd1;
            if (ticks_inc >= anim_limit_r)
              anim_running_nxt = 1'b0;
          end
        end
        nixie_pkg::CMD_REFRESH: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hour_r   <= '0;
      clock_minute_r <= '0;
      blink_phase_r  <= 1'b0;
      anim_running_r <= 1'b0;
      anim_ticks_r   <= '0;
      anim_limit_r   <= '0;
      anim_digit_r   <= '0;
    end else begin
      clock_hour_r   <= clock_hour_nxt;
      clock_minute_r <= clock_minute_nxt;
      blink_phase_r  <= blink_phase_nxt;
      anim_running_r <= anim_running_nxt;
      anim_ticks_r   <= anim_ticks_nxt;
      anim_limit_r   <= anim_limit_nxt;
      anim_digit_r   <= anim_digit_nxt;
    end
  end

  // minute of day, hour*60 as hour*64 - hour*4
  assign now = {clock_hour_nxt, 6'b000000} - {4'b0000, clock_hour_nxt, 2'b00}
             + {5'b00000, clock_minute_nxt};

  always_comb begin
    if (cfg.sleep_start_minute <= cfg.sleep_end_minute)
      in_sleep = (now >= cfg.sleep_start_minute) && (now < cfg.sleep_end_minute);
    else
      in_sleep = (now >= cfg.sleep_start_minute) || (now < cfg.sleep_end_minute);
  end

  always_comb begin
    res.digit_one   = 4'd0;
    res.digit_two   = 4'd0;
    res.digit_three = 4'd0;
    res.digit_four  = 4'd0;
    res.tubes_blank = 1'b0;
    if (anim_running_nxt) begin
      res.digit_one   = anim_digit_nxt;
      res.digit_two   = anim_digit_nxt;
      res.digit_three = anim_digit_nxt;
      res.digit_four  = anim_digit_nxt;
    end else if (!mf[nixie_pkg::MODE_TUBES]) begin
      res.tubes_blank = 1'b1;
    end else if (mf[nixie_pkg::MODE_MANUAL]) begin
      res.digit_one   = cfg.manual_digits[15:12];
      res.digit_two   = cfg.manual_digits[11:8];
      res.digit_three = cfg.manual_digits[7:4];
      res.digit_four  = cfg.manual_digits[3:0];
    end else if (mf[nixie_pkg::MODE_SLEEP] && in_sleep) begin
      res.tubes_blank = 1'b1;
    end else begin
      res.digit_one   = nixie_pkg::div10({1'b0, clock_hour_nxt});
      res.digit_two   = nixie_pkg::mod10({1'b0, clock_hour_nxt});
      res.digit_three = nixie_pkg::div10(clock_minute_nxt);
      res.digit_four  = nixie_pkg::mod10(clock_minute_nxt);
    end

    // colon lamp
    if (!mf[nixie_pkg::MODE_LAMP])
      res.neon_lit = 1'b0;
    else if (mf[nixie_pkg::MODE_BLINK])
      res.neon_lit = blink_phase_nxt;
    else
      res.neon_lit = 1'b1;

    res.animating = anim_running_nxt;
  end

endmodule
`default_nettype wire

@@ verif/nixie_clock_display_controller_core_test.sv @@
`timescale 1ns / 100ps

module nixie_clock_display_controller_core_test;
  import nixie_pkg::*;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // event stream into the block
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata  = '0;    // hour[4:0], minute[10:5], first_half[11], zero
  logic [1:0]  in_tuser  = '0;    // command[1:0]

  // display stream out of the block
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // digit_one[3:0], digit_two[7:4], digit_three[11:8],
                                  // digit_four[15:12], tubes_blank[16], neon_lit[17],
                                  // animating[18], zero

  // register port
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // events waiting to be offered, and the display each accepted event should give
  item_t   event_q [$];
  result_t expected_display [$];
  item_t   cur_event;

  // register copy and tube state as the predictor sees them
  cfg_t        regs;
  logic [4:0]  tm_hour;
  logic [5:0]  tm_minute;
  logic        blink_half;
  logic        cycling;
  logic [11:0] cycle_count;
  logic [11:0] cycle_limit;
  logic [3:0]  cycle_digit;

  // idling control
  logic no_idle     = 1'b0;   // both sides run flat out while set
  logic pressure_go = 1'b0;   // asks for one long receiver hold-off
  logic hold_rx     = 1'b0;
  int   tx_wait     = 0;
  int   tx_gap;
  int   rx_wait     = 0;
  int   rx_gap;
  int   mismatches  = 0;

  nixie_clock_display_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t error: %s", $time, what);
  endtask

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // applies one event to the tube state and works out what the tubes show after it
  function automatic result_t advance_display(input item_t ev);
    result_t r;
    int      secs;
    int      limit;
    int      now;
    logic    start;
    logic    asleep;
    r = '0;
    start = 1'b0;
    limit = 0;
    case (ev.command)
      CMD_MINUTE: begin
        tm_hour = ev.hour;
        tm_minute = ev.minute;
        // on the hour a new animation may start, never over a running one
        if (!cycling && ev.minute == 0) begin
          if (regs.mode_flags[MODE_FIXED] && ev.hour == regs.fixed_anim_hour) begin
            secs = int'(regs.fixed_anim_seconds);
            if (secs > MAX_ANIM_SECONDS) secs = MAX_ANIM_SECONDS;
            start = 1'b1;
            limit = secs * 10;
          end else if (regs.mode_flags[MODE_HOURLY]) begin
            start = 1'b1;
            limit = 10;
          end
        end
        if (start) begin
          cycling = 1'b1;
          cycle_digit = '0;
          cycle_count = '0;
          cycle_limit = (limit > TICK_MAX) ? TICK_MAX : limit[11:0];
        end
      end
      CMD_HALF_SEC: blink_half = ev.first_half;
      CMD_ANIM_TICK: begin
        // ticks only count while an animation runs
        if (cycling) begin
          cycle_count = cycle_count + 12'd1;
          cycle_digit = 4'(cycle_count % 12'd10);
          if (cycle_count >= cycle_limit) cycling = 1'b0;
        end
      end
      default: ;
    endcase

    // sleep window, wrapping past midnight when start lies after end
    now = tm_hour * 60 + tm_minute;
    if (regs.sleep_start_minute <= regs.sleep_end_minute)
      asleep = (now >= regs.sleep_start_minute) && (now < regs.sleep_end_minute);
    else
      asleep = (now >= regs.sleep_start_minute) || (now < regs.sleep_end_minute);

    // priority: animation, tubes off, manual digits, sleep, clock
    if (cycling) begin
      r.digit_one = cycle_digit;
      r.digit_two = cycle_digit;
      r.digit_three = cycle_digit;
      r.digit_four = cycle_digit;
    end else if (!regs.mode_flags[MODE_TUBES]) begin
      r.tubes_blank = 1'b1;
    end else if (regs.mode_flags[MODE_MANUAL]) begin
      r.digit_one = regs.manual_digits[15:12];
      r.digit_two = regs.manual_digits[11:8];
      r.digit_three = regs.manual_digits[7:4];
      r.digit_four = regs.manual_digits[3:0];
    end else if (regs.mode_flags[MODE_SLEEP] && asleep) begin
      r.tubes_blank = 1'b1;
    end else begin
      r.digit_one = 4'(tm_hour / 5'd10);
      r.digit_two = 4'(tm_hour % 5'd10);
      r.digit_three = 4'(tm_minute / 6'd10);
      r.digit_four = 4'(tm_minute % 6'd10);
    end

    if (!regs.mode_flags[MODE_LAMP])
      r.neon_lit = 1'b0;
    else if (regs.mode_flags[MODE_BLINK])
      r.neon_lit = blink_half;
    else
      r.neon_lit = 1'b1;
    r.animating = cycling;
    return r;
  endfunction

  // compares one display item with the oldest expectation, field by field
  task automatic check_display(input logic [23:0] word);
    result_t want;
    int      got_f [7];
    int      want_f [7];
    string   field_name [7];
    if (expected_display.size() == 0) begin
      flag_mismatch($sformatf("display item %h with nothing expected", word));
      return;
    end
    want = expected_display.pop_front();
    field_name = '{"digit_one", "digit_two", "digit_three", "digit_four",
                   "tubes_blank", "neon_lit", "animating"};
    got_f = '{int'(word[3:0]), int'(word[7:4]), int'(word[11:8]), int'(word[15:12]),
              int'(word[16]), int'(word[17]), int'(word[18])};
    want_f = '{int'(want.digit_one), int'(want.digit_two), int'(want.digit_three),
               int'(want.digit_four), int'(want.tubes_blank), int'(want.neon_lit),
               int'(want.animating)};
    for (int k = 0; k < 7; k++)
      if (got_f[k] != want_f[k])
        flag_mismatch($sformatf("%s is %0d, expected %0d", field_name[k], got_f[k],
                                want_f[k]));
  endtask

  // sender: offers queued events, predicts each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_wait <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_display.push_back(advance_display(cur_event));
        tx_gap = draw_idle();
      end else begin
        tx_gap = tx_wait;
      end
      if (tx_gap == 0 && event_q.size() != 0) begin
        cur_event = event_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, cur_event.first_half, cur_event.minute, cur_event.hour};
        in_tuser <= cur_event.command;
        tx_wait <= 0;
      end else begin
        in_tvalid <= 1'b0;
        tx_wait <= (tx_gap > 0) ? tx_gap - 1 : 0;
      end
    end
  end

  // receiver: takes display items with random stalls, checks each one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_display(out_tdata);
        rx_gap = draw_idle();
      end else begin
        rx_gap = (rx_wait > 0) ? rx_wait - 1 : 0;
      end
      rx_wait <= rx_gap;
      out_tready <= (rx_gap == 0) && !hold_rx;
    end
  end

  // one long receiver hold-off so that both pipeline stages fill and in_tready drops
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (60) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic queue_event(input logic [1:0] cmd, input int hr, input int mn,
                             input logic half);
    item_t ev;
    ev.command = cmd;
    ev.hour = hr[4:0];
    ev.minute = mn[5:0];
    ev.first_half = half;
    event_q.push_back(ev);
  endtask

  // random event, mostly well-formed times with a share of out-of-range noise
  function automatic item_t random_event();
    item_t ev;
    int    roll;
    ev = item_t'(14'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      ev.command = CMD_ANIM_TICK;
    end else if (roll < 60) begin
      ev.command = CMD_MINUTE;
      if ($urandom_range(0, 19) != 0) begin
        ev.hour = ($urandom_range(0, 3) == 0) ? regs.fixed_anim_hour :
                                                5'($urandom_range(0, 23));
        ev.minute = ($urandom_range(0, 4) < 2) ? 6'd0 : 6'($urandom_range(0, 59));
      end
    end else if (roll < 85) begin
      ev.command = CMD_HALF_SEC;
    end else begin
      ev.command = CMD_REFRESH;
    end
    return ev;
  endfunction

  // waits until every offered event has been shown and checked, with a limit
  task automatic wait_quiet();
    for (int n = 0; n < 5000 && (event_q.size() != 0 || in_tvalid ||
                                 expected_display.size() != 0); n++)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup then access cycle; the register copy follows at the write edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_MODE:        regs.mode_flags = val[6:0];
      REG_MANUAL:      regs.manual_digits = val[15:0];
      REG_SLEEP_START: regs.sleep_start_minute = val[10:0];
      REG_SLEEP_END:   regs.sleep_end_minute = val[10:0];
      REG_ANIM_HOUR:   regs.fixed_anim_hour = val[4:0];
      REG_ANIM_SECS:   regs.fixed_anim_seconds = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // register settings per random phase: extremes first and last, random between
  task automatic choose_settings(input int phase);
    logic [31:0] v [6];
    case (phase)
      0: v = '{127, 16'hFFFF, 2047, 0, 31, 0};
      1: v = '{7'h61, 0, 0, 2047, 0, 1};
      7: v = '{7'h69, 16'h1234, 600, 660, $urandom_range(0, 23), 255};
      default: begin
        v[0] = $urandom_range(0, 127) | ($urandom_range(0, 3) != 0);
        v[1] = $urandom_range(0, 65535);
        v[2] = $urandom_range(0, 1) ? $urandom_range(0, 1439) : $urandom_range(0, 2047);
        v[3] = $urandom_range(0, 1) ? $urandom_range(0, 1439) : $urandom_range(0, 2047);
        v[4] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
        v[5] = $urandom_range(0, 3);
      end
    endcase
    write_reg(REG_MODE, v[0]);
    write_reg(REG_MANUAL, v[1]);
    write_reg(REG_SLEEP_START, v[2]);
    write_reg(REG_SLEEP_END, v[3]);
    write_reg(REG_ANIM_HOUR, v[4]);
    write_reg(REG_ANIM_SECS, v[5]);
  endtask

  initial begin
    regs = '0;
    regs.mode_flags = MODE_RESET;
    tm_hour = '0;
    tm_minute = '0;
    blink_half = 1'b0;
    cycling = 1'b0;
    cycle_count = '0;
    cycle_limit = '0;
    cycle_digit = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: tubes on, lamp blinking
    queue_event(CMD_REFRESH, 0, 0, 1'b0);
    queue_event(CMD_HALF_SEC, 0, 0, 1'b1);
    queue_event(CMD_MINUTE, 23, 59, 1'b0);
    queue_event(CMD_MINUTE, 31, 63, 1'b1);      // time out of range, shown as given
    queue_event(CMD_ANIM_TICK, 0, 0, 1'b0);     // no animation, ignored
    queue_event(CMD_MINUTE, 0, 0, 1'b0);        // on the hour but no animation enabled

    // fixed animation of zero length at 07, hourly animation otherwise
    wait_quiet();
    write_reg(REG_MODE, 7'h69);
    write_reg(REG_MANUAL, 16'h9A0F);
    write_reg(REG_SLEEP_START, 1380);
    write_reg(REG_SLEEP_END, 420);
    write_reg(REG_ANIM_HOUR, 7);
    write_reg(REG_ANIM_SECS, 0);
    queue_event(CMD_MINUTE, 7, 0, 1'b0);
    queue_event(CMD_MINUTE, 8, 0, 1'b0);        // during the animation, time only
    queue_event(CMD_ANIM_TICK, 0, 0, 1'b0);     // zero length stops at the first tick
    queue_event(CMD_MINUTE, 9, 0, 1'b0);        // hourly animation, ten ticks
    queue_event(CMD_ANIM_TICK, 0, 0, 1'b0);
    queue_event(CMD_ANIM_TICK, 0, 0, 1'b0);

    // animation outranks tubes off
    wait_quiet();
    write_reg(REG_MODE, 7'h02);
    queue_event(CMD_REFRESH, 0, 0, 1'b0);

    // animation runs out, then manual digits with nibbles above nine
    wait_quiet();
    write_reg(REG_MODE, 7'h03);
    repeat (8) queue_event(CMD_ANIM_TICK, 0, 0, 1'b0);

    // sleep window wrapping past midnight
    wait_quiet();
    write_reg(REG_MODE, 7'h05);
    queue_event(CMD_MINUTE, 23, 30, 1'b0);
    queue_event(CMD_MINUTE, 12, 0, 1'b0);
    queue_event(CMD_MINUTE, 4, 15, 1'b0);

    // bounds beyond a day: empty window
    wait_quiet();
    write_reg(REG_SLEEP_START, 2047);
    write_reg(REG_SLEEP_END, 2047);
    queue_event(CMD_MINUTE, 23, 59, 1'b0);

    // everything off
    wait_quiet();
    write_reg(REG_MODE, 7'h00);
    queue_event(CMD_REFRESH, 0, 0, 1'b0);

    // random phases, each with its own settings
    for (int phase = 0; phase < 8; phase++) begin
      wait_quiet();
      choose_settings(phase);
      no_idle <= (phase == 2 || phase == 3 || phase == 6);
      if (phase == 3) pressure_go <= 1'b1;
      repeat (62) event_q.push_back(random_event());
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (expected_display.size() != 0)
      flag_mismatch($sformatf("%0d display items never arrived", expected_display.size()));
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
